// ----- hw/rtl/cmbs_pkg.sv -----
// Shared types and constants for the cellular modem bring-up sequencer.
// No dependencies; used by cmbs_step and the sequencer core.
package cmbs_pkg;

    // Fixed widths of the item fields and registers
    localparam int TimeW  = 32;
    localparam int SpanW  = 20;
    localparam int ShortW = 16;
    localparam int CfgIdxW = 3;

    // Poll interval while waiting for network registration
    localparam logic [TimeW-1:0] REG_POLL_MS = 32'd2000;

    // Register reset values
    localparam logic [ShortW-1:0] PWRKEY_PULSE_RST  = 16'd1500;
    localparam logic [ShortW-1:0] BOOT_WAIT_RST     = 16'd3000;
    localparam logic [SpanW-1:0]  AT_TIMEOUT_RST    = 20'd30000;
    localparam logic [SpanW-1:0]  SIM_POLL_RST      = 20'd30000;
    localparam logic [SpanW-1:0]  REG_TIMEOUT_RST   = 20'd120000;
    localparam logic [ShortW-1:0] READY_POLL_RST    = 16'd10000;
    localparam logic [SpanW-1:0]  BACKOFF_INIT_RST  = 20'd15000;
    localparam logic [SpanW-1:0]  BACKOFF_MAX_RST   = 20'd300000;

    // Retry wait after reset
    localparam logic [SpanW-1:0]  RETRY_WAIT_RST    = 20'd15000;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_PWRKEY_PULSE = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_BOOT_WAIT    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_AT_TIMEOUT   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SIM_POLL     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_REG_TIMEOUT  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_READY_POLL   = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_BACKOFF_INIT = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_BACKOFF_MAX  = 3'd7;

    // Link state codes
    typedef enum logic [3:0] {
        ST_OFF      = 4'd0,
        ST_PULSE    = 4'd1,
        ST_WAIT_AT  = 4'd2,
        ST_INIT     = 4'd3,
        ST_NO_SIM   = 4'd4,
        ST_WAIT_NET = 4'd5,
        ST_ATTACH   = 4'd6,
        ST_READY    = 4'd7,
        ST_BACKOFF  = 4'd8
    } link_state_t;

    // Tick item
    typedef struct packed {
        logic [TimeW-1:0] now_ms;
        logic             at_ok;
        logic             sim_present;
        logic             init_ok;
        logic             net_registered;
        logic             attach_ok;
        logic             data_connected;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [3:0] link_state;
        logic       pwrkey_drive;
        logic       reset_pulse;
        logic       link_ready;
        logic       signal_poll;
    } out_item_t;

    // Configuration register file
    typedef struct packed {
        logic [ShortW-1:0] pwrkey_pulse_ms;
        logic [ShortW-1:0] boot_wait_ms;
        logic [SpanW-1:0]  at_timeout_ms;
        logic [SpanW-1:0]  sim_poll_ms;
        logic [SpanW-1:0]  registration_timeout_ms;
        logic [ShortW-1:0] ready_poll_ms;
        logic [SpanW-1:0]  backoff_initial_ms;
        logic [SpanW-1:0]  backoff_max_ms;
    } cfg_regs_t;

    // Sequencer state carried from tick to tick
    typedef struct packed {
        link_state_t      seq_state;
        logic [TimeW-1:0] state_entry_time;
        logic [TimeW-1:0] last_poll_time;
        logic [SpanW-1:0] retry_wait;
        logic             pwrkey_level;
    } seq_state_t;

endpackage

// ----- hw/rtl/cellular_modem_bringup_sequencer_core.sv -----
// Cellular modem bring-up sequencer, top level: handshakes, registers, state.
// Depends on cmbs_pkg and cmbs_step.
//
// Takes one tick transfer per clock while the tick side is not stalled and returns exactly one result per tick.
// A tick is captured in an input register, stepped through the combinational
// sequencer logic and lands in the result register, so a result is presented once
// its tick has passed both registers, and the sustained rate is one tick per cycle
// as long as the result side does not stall. The stall to the tick side is raised
// only while a captured tick cannot move because the result register is held.
// Configuration writes are always taken (cfg_ready is high) and should be made
// while no tick is in flight; indexes follow the register list from 0.
module cellular_modem_bringup_sequencer_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Tick channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  cmbs_pkg::in_item_t                   in_data,
    // Result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output cmbs_pkg::out_item_t                  out_data,
    // Configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cmbs_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [cmbs_pkg::SpanW-1:0]           cfg_data
);

    logic                 in_valid_reg;
    cmbs_pkg::in_item_t   in_item_reg;
    logic                 out_valid_reg;
    cmbs_pkg::out_item_t  out_item_reg;
    cmbs_pkg::cfg_regs_t  cfg_reg;
    cmbs_pkg::seq_state_t state_reg;
    cmbs_pkg::seq_state_t state_next;
    cmbs_pkg::out_item_t  result;
    logic                 advance;
    logic                 step;
    logic                 in_xfer;

    // Pipeline flow control
    assign advance   = !out_valid_reg || !out_stall;
    assign step      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // Sequencer step
    cmbs_step u_step (
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .item   (in_item_reg),
        .nxt    (state_next),
        .result (result)
    );

    // Input register: empty slot fills even while the result is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            in_item_reg <= in_data;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_item_reg <= result;
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.seq_state        <= cmbs_pkg::ST_OFF;
            state_reg.state_entry_time <= '0;
            state_reg.last_poll_time   <= '0;
            state_reg.retry_wait       <= cmbs_pkg::RETRY_WAIT_RST;
            state_reg.pwrkey_level     <= 1'b0;
        end
        else if (step)
            state_reg <= state_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pwrkey_pulse_ms         <= cmbs_pkg::PWRKEY_PULSE_RST;
            cfg_reg.boot_wait_ms            <= cmbs_pkg::BOOT_WAIT_RST;
            cfg_reg.at_timeout_ms           <= cmbs_pkg::AT_TIMEOUT_RST;
            cfg_reg.sim_poll_ms             <= cmbs_pkg::SIM_POLL_RST;
            cfg_reg.registration_timeout_ms <= cmbs_pkg::REG_TIMEOUT_RST;
            cfg_reg.ready_poll_ms           <= cmbs_pkg::READY_POLL_RST;
            cfg_reg.backoff_initial_ms      <= cmbs_pkg::BACKOFF_INIT_RST;
            cfg_reg.backoff_max_ms          <= cmbs_pkg::BACKOFF_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cmbs_pkg::REG_PWRKEY_PULSE:
                    cfg_reg.pwrkey_pulse_ms <= cfg_data[cmbs_pkg::ShortW-1:0];
                cmbs_pkg::REG_BOOT_WAIT:
                    cfg_reg.boot_wait_ms <= cfg_data[cmbs_pkg::ShortW-1:0];
                cmbs_pkg::REG_AT_TIMEOUT:
                    cfg_reg.at_timeout_ms <= cfg_data;
                cmbs_pkg::REG_SIM_POLL:
                    cfg_reg.sim_poll_ms <= cfg_data;
                cmbs_pkg::REG_REG_TIMEOUT:
                    cfg_reg.registration_timeout_ms <= cfg_data;
                cmbs_pkg::REG_READY_POLL:
                    cfg_reg.ready_poll_ms <= cfg_data[cmbs_pkg::ShortW-1:0];
                cmbs_pkg::REG_BACKOFF_INIT:
                    cfg_reg.backoff_initial_ms <= cfg_data;
                cmbs_pkg::REG_BACKOFF_MAX:
                    cfg_reg.backoff_max_ms <= cfg_data;
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ----- hw/rtl/cmbs_step.sv -----
// One tick of the bring-up sequencer: next state and result from the current state.
// Depends on cmbs_pkg for the state, item and register types.
module cmbs_step (
    input  cmbs_pkg::cfg_regs_t  cfg,
    input  cmbs_pkg::seq_state_t cur,
    input  cmbs_pkg::in_item_t   item,
    output cmbs_pkg::seq_state_t nxt,
    output cmbs_pkg::out_item_t  result
);

    logic [cmbs_pkg::TimeW-1:0] elapsed;
    logic [cmbs_pkg::TimeW-1:0] since_poll;
    logic [cmbs_pkg::SpanW:0]   doubled;
    logic                       rst_pulse;
    logic                       poll;

    // Modular time spans
    assign elapsed    = item.now_ms - cur.state_entry_time;
    assign since_poll = item.now_ms - cur.last_poll_time;
    assign doubled    = {cur.retry_wait, 1'b0};

    // Transition logic
    always_comb
    begin
        nxt       = cur;
        rst_pulse = 1'b0;
        poll      = 1'b0;
        unique case (cur.seq_state)
            cmbs_pkg::ST_PULSE:
            begin
                if (elapsed >= {16'd0, cfg.pwrkey_pulse_ms})
                begin
                    nxt.pwrkey_level     = 1'b0;
                    nxt.seq_state        = cmbs_pkg::ST_WAIT_AT;
                    nxt.state_entry_time = item.now_ms;
                end
            end
            cmbs_pkg::ST_WAIT_AT:
            begin
                if (elapsed >= {16'd0, cfg.boot_wait_ms})
                begin
                    if (item.at_ok)
                    begin
                        nxt.seq_state        = cmbs_pkg::ST_INIT;
                        nxt.state_entry_time = item.now_ms;
                    end
                    else if (elapsed > {12'd0, cfg.at_timeout_ms})
                    begin
                        nxt.seq_state        = cmbs_pkg::ST_BACKOFF;
                        nxt.state_entry_time = item.now_ms;
                    end
                end
            end
            cmbs_pkg::ST_INIT:
            begin
                nxt.state_entry_time = item.now_ms;
                if (!item.sim_present)
                    nxt.seq_state = cmbs_pkg::ST_NO_SIM;
                else if (item.init_ok)
                    nxt.seq_state = cmbs_pkg::ST_WAIT_NET;
                else
                    nxt.seq_state = cmbs_pkg::ST_BACKOFF;
            end
            cmbs_pkg::ST_NO_SIM:
            begin
                // Each poll interval: restart it in place, and return to init once the SIM is present
                if (elapsed >= {12'd0, cfg.sim_poll_ms})
                begin
                    nxt.state_entry_time = item.now_ms;
                    if (item.sim_present)
                        nxt.seq_state = cmbs_pkg::ST_INIT;
                end
            end
            cmbs_pkg::ST_WAIT_NET:
            begin
                if (since_poll >= cmbs_pkg::REG_POLL_MS)
                begin
                    nxt.last_poll_time = item.now_ms;
                    if (item.net_registered)
                    begin
                        nxt.seq_state        = cmbs_pkg::ST_ATTACH;
                        nxt.state_entry_time = item.now_ms;
                    end
                    else if (elapsed > {12'd0, cfg.registration_timeout_ms})
                    begin
                        nxt.seq_state        = cmbs_pkg::ST_BACKOFF;
                        nxt.state_entry_time = item.now_ms;
                    end
                end
            end
            cmbs_pkg::ST_ATTACH:
            begin
                nxt.state_entry_time = item.now_ms;
                nxt.seq_state = item.attach_ok ? cmbs_pkg::ST_READY : cmbs_pkg::ST_BACKOFF;
            end
            cmbs_pkg::ST_READY:
            begin
                if (since_poll >= {16'd0, cfg.ready_poll_ms})
                begin
                    nxt.last_poll_time = item.now_ms;
                    poll               = 1'b1;
                    if (!item.net_registered || !item.data_connected)
                    begin
                        nxt.seq_state        = cmbs_pkg::ST_BACKOFF;
                        nxt.state_entry_time = item.now_ms;
                    end
                end
            end
            cmbs_pkg::ST_BACKOFF:
            begin
                // Expired: hard reset, double the wait up to the ceiling
                if (elapsed >= {12'd0, cur.retry_wait})
                begin
                    nxt.retry_wait = (doubled < {1'b0, cfg.backoff_max_ms}) ?
                                     doubled[cmbs_pkg::SpanW-1:0] : cfg.backoff_max_ms;
                    rst_pulse            = 1'b1;
                    nxt.seq_state        = cmbs_pkg::ST_WAIT_AT;
                    nxt.state_entry_time = item.now_ms;
                end
            end
            default:
            begin
                // Off, and any stray code: skip the power key if the modem answers
                nxt.state_entry_time = item.now_ms;
                if (item.at_ok)
                    nxt.seq_state = cmbs_pkg::ST_INIT;
                else
                begin
                    nxt.pwrkey_level = 1'b1;
                    nxt.seq_state    = cmbs_pkg::ST_PULSE;
                end
            end
        endcase

        // Ready link restores the initial retry wait
        if (nxt.seq_state == cmbs_pkg::ST_READY)
            nxt.retry_wait = cfg.backoff_initial_ms;
    end

    // Result fields
    always_comb
    begin
        result.link_state   = nxt.seq_state;
        result.pwrkey_drive = nxt.pwrkey_level;
        result.reset_pulse  = rst_pulse;
        result.link_ready   = (nxt.seq_state == cmbs_pkg::ST_READY);
        result.signal_poll  = poll;
    end

endmodule
